/* hdl/cks_pkg.sv */
package cks_pkg;

  // frame limits
  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_CHANNELS  = 4;
  localparam int MAX_HEIGHT    = 4096;
  localparam int KERNEL_CENTER = 5;

  // history: two component rows plus a short window of the newest items
  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int WIN_DEPTH  = MAX_CHANNELS + 1;
  localparam int HIST_DEPTH = 2 * LINE_DEPTH + 2 * MAX_CHANNELS + 1;

  // field and register widths
  localparam int PIX_W = 8;
  localparam int FW_W  = 12;
  localparam int FH_W  = 13;
  localparam int CC_W  = 3;

  // derived widths
  localparam int WU_W  = $clog2(MAX_WIDTH + 1);
  localparam int HU_W  = $clog2(MAX_HEIGHT + 1);
  localparam int CU_W  = $clog2(MAX_CHANNELS + 1);
  localparam int LEN_W = $clog2(LINE_DEPTH + MAX_CHANNELS + 1);
  localparam int HA_W  = $clog2(HIST_DEPTH);
  localparam int CNT_W = $clog2(HIST_DEPTH + 1);
  localparam int COL_W = $clog2(LINE_DEPTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WI_W  = $clog2(WIN_DEPTH);
  localparam int ACC_W = PIX_W + 4;

  // result queue
  localparam int OF_DEPTH = 4;
  localparam int OF_AW    = $clog2(OF_DEPTH);
  localparam int OF_CW    = $clog2(OF_DEPTH + 1);

  // item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // neighbor lookup request, one per result
  typedef struct packed {
    logic             valid;
    logic             border;
    logic             last;
    logic             up_ok;
    logic             left_ok;
    logic             right_ok;
    logic [HA_W-1:0]  up_back;
    logic [HA_W-1:0]  left_back;
    logic [HA_W-1:0]  ctr_back;
    logic [HA_W-1:0]  right_back;
    logic [HA_W-1:0]  wp_post;
    logic [PIX_W-1:0] down_val;
  } cks_req_t;

  // neighbors read from the history, zero where not available
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] right;
  } cks_taps_t;

  // control traveling beside the history read
  typedef struct packed {
    logic             valid;
    logic             border;
    logic             last;
    logic [PIX_W-1:0] down;
  } cks_pipe_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             border;
    logic             last;
  } cks_res_t;

endpackage

/* hdl/cks_ctrl.sv */
module cks_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cks_pkg::FW_W-1:0]  frame_width,
  input  logic [cks_pkg::FH_W-1:0]  frame_height,
  input  logic [cks_pkg::CC_W-1:0]  channel_count,
  input  logic                      accept,
  input  logic                      mode,
  input  logic [cks_pkg::PIX_W-1:0] component,
  output logic                      wr_en,
  output logic [cks_pkg::HA_W-1:0]  wr_addr,
  output logic [cks_pkg::PIX_W-1:0] wr_data,
  output cks_pkg::cks_req_t         req_r
);
  import cks_pkg::*;

  logic [WU_W-1:0]  w_use;
  logic [HU_W-1:0]  h_use;
  logic [CU_W-1:0]  c_use;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] lag;

  logic [HA_W-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] wnd_r [WIN_DEPTH];
  logic [PIX_W-1:0] wnd_nxt [WIN_DEPTH];

  logic             is_pix, is_drain, produce;
  logic [CNT_W-1:0] pend_inc, pend_base, k;
  logic [CNT_W:0]   up_b, left_b;
  logic [CNT_W-1:0] right_b, down_b;
  logic             down_ok;
  logic [COL_W:0]   col_inc, col_far;
  logic [ROW_W:0]   row_inc;
  logic             col_wrap, row_wrap, border, last;

  // used sizes, saturated to the supported range
  always_comb begin
    if (frame_width < FW_W'(3))          w_use = WU_W'(3);
    else if (32'(frame_width) > MAX_WIDTH) w_use = WU_W'(MAX_WIDTH);
    else                                 w_use = WU_W'(frame_width);
    if (frame_height < FH_W'(3))           h_use = HU_W'(3);
    else if (32'(frame_height) > MAX_HEIGHT) h_use = HU_W'(MAX_HEIGHT);
    else                                   h_use = HU_W'(frame_height);
    if (channel_count == '0)                   c_use = CU_W'(1);
    else if (32'(channel_count) > MAX_CHANNELS) c_use = CU_W'(MAX_CHANNELS);
    else                                       c_use = CU_W'(channel_count);
  end

  assign len = LEN_W'(w_use) * LEN_W'(c_use);
  assign lag = len + LEN_W'(c_use);

  // pending count and result decision
  assign is_pix   = accept && (mode == MODE_PIXEL);
  assign is_drain = accept && (mode == MODE_DRAIN);
  assign pend_inc = (pend_r < CNT_W'(HIST_DEPTH)) ? pend_r + CNT_W'(1) : pend_r;
  assign pend_base = is_pix ? pend_inc : pend_r;
  assign produce  = is_pix ? (pend_inc > CNT_W'(lag)) : (is_drain && (pend_r != '0));
  assign k        = pend_base - CNT_W'(1);
  assign pend_nxt = produce ? k : pend_base;

  // history write pointer
  assign wr_en   = is_pix;
  assign wr_addr = wp_r;
  assign wr_data = component;
  always_comb begin
    wp_nxt = wp_r;
    if (is_pix) begin
      wp_nxt = (wp_r == HA_W'(HIST_DEPTH - 1)) ? '0 : wp_r + HA_W'(1);
    end
  end

  // newest items, shifted on component transfers
  always_comb begin
    wnd_nxt[0] = is_pix ? component : wnd_r[0];
    for (int i = 1; i < WIN_DEPTH; i++) begin
      wnd_nxt[i] = is_pix ? wnd_r[i-1] : wnd_r[i];
    end
  end

  // neighbor distances back from the newest item
  assign up_b    = {1'b0, k} + (CNT_W+1)'(len);
  assign left_b  = {1'b0, k} + (CNT_W+1)'(c_use);
  assign right_b = k - CNT_W'(c_use);
  assign down_b  = k - CNT_W'(len);
  assign down_ok = (k >= CNT_W'(len)) && (down_b < CNT_W'(WIN_DEPTH));

  // output position
  assign col_inc  = {1'b0, col_r} + (COL_W+1)'(1);
  assign col_far  = {1'b0, col_r} + (COL_W+1)'(c_use);
  assign row_inc  = {1'b0, row_r} + (ROW_W+1)'(1);
  assign col_wrap = 32'(col_inc) >= 32'(len);
  assign row_wrap = 32'(row_inc) >= 32'(h_use);
  assign border   = (row_r == '0) || row_wrap ||
                    (32'(col_r) < 32'(c_use)) || (32'(col_far) >= 32'(len));
  assign last     = col_wrap && row_wrap;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (produce) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : ROW_W'(row_inc);
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      pend_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      req_r.valid <= 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) wnd_r[i] <= '0;
    end else begin
      wp_r        <= wp_nxt;
      pend_r      <= pend_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      req_r.valid <= produce;
      for (int i = 0; i < WIN_DEPTH; i++) wnd_r[i] <= wnd_nxt[i];
    end
    req_r.border     <= border;
    req_r.last       <= last;
    req_r.up_ok      <= up_b < (CNT_W+1)'(HIST_DEPTH);
    req_r.left_ok    <= left_b < (CNT_W+1)'(HIST_DEPTH);
    req_r.right_ok   <= k >= CNT_W'(c_use);
    req_r.up_back    <= HA_W'(up_b);
    req_r.left_back  <= HA_W'(left_b);
    req_r.ctr_back   <= HA_W'(k);
    req_r.right_back <= HA_W'(right_b);
    req_r.wp_post    <= wp_nxt;
    req_r.down_val   <= down_ok ? wnd_nxt[WI_W'(down_b)] : '0;
  end

endmodule

/* hdl/cks_hist.sv */
module cks_hist (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [cks_pkg::HA_W-1:0]  wr_addr,
  input  logic [cks_pkg::PIX_W-1:0] wr_data,
  input  cks_pkg::cks_req_t         req,
  output cks_pkg::cks_taps_t        taps
);
  import cks_pkg::*;

  // two copies of the history, each with two read ports
  logic [PIX_W-1:0] copy_a [HIST_DEPTH];
  logic [PIX_W-1:0] copy_b [HIST_DEPTH];

  logic [PIX_W-1:0] up_q, left_q, ctr_q, right_q;
  logic             up_ok_q, left_ok_q, right_ok_q;

  // address of the item 'back' places before the newest one
  function automatic logic [HA_W-1:0] back_addr(input logic [HA_W-1:0] wp_post,
                                                input logic [HA_W-1:0] back);
    logic [HA_W:0] t;
    t = ({1'b0, wp_post} + (HA_W+1)'(HIST_DEPTH - 1)) - {1'b0, back};
    if (t >= (HA_W+1)'(HIST_DEPTH)) t = t - (HA_W+1)'(HIST_DEPTH);
    return HA_W'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      copy_a[wr_addr] <= wr_data;
      copy_b[wr_addr] <= wr_data;
    end
    up_q       <= copy_a[back_addr(req.wp_post, req.up_back)];
    left_q     <= copy_a[back_addr(req.wp_post, req.left_back)];
    ctr_q      <= copy_b[back_addr(req.wp_post, req.ctr_back)];
    right_q    <= copy_b[back_addr(req.wp_post, req.right_back)];
    up_ok_q    <= req.up_ok;
    left_ok_q  <= req.left_ok;
    right_ok_q <= req.right_ok;
  end

  assign taps.up    = up_ok_q ? up_q : '0;
  assign taps.left  = left_ok_q ? left_q : '0;
  assign taps.ctr   = ctr_q;
  assign taps.right = right_ok_q ? right_q : '0;

endmodule

/* hdl/cks_calc.sv */
module cks_calc (
  input  cks_pkg::cks_taps_t taps,
  input  cks_pkg::cks_pipe_t pipe,
  output cks_pkg::cks_res_t  res
);
  import cks_pkg::*;

  logic [ACC_W-1:0] acc;

  // 5*center minus the four neighbors, two's complement
  assign acc = ACC_W'(KERNEL_CENTER) * ACC_W'(taps.ctr) - ACC_W'(taps.up)
             - ACC_W'(taps.left) - ACC_W'(taps.right) - ACC_W'(pipe.down);

  always_comb begin
    res.border = pipe.border;
    res.last   = pipe.last;
    if (pipe.border || acc[ACC_W-1]) begin
      res.value = '0;
    end else if (acc > ACC_W'(255)) begin
      res.value = PIX_W'(255);
    end else begin
      res.value = PIX_W'(acc);
    end
  end

endmodule

/* hdl/cks_ofifo.sv */
module cks_ofifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  cks_pkg::cks_res_t         wr_data,
  input  logic                      rd_en,
  output logic                      rd_valid,
  output cks_pkg::cks_res_t         rd_data,
  output logic [cks_pkg::OF_CW-1:0] count
);
  import cks_pkg::*;

  cks_res_t         slot_r [OF_DEPTH];
  logic [OF_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OF_CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + OF_AW'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + OF_AW'(1);
      cnt_r <= cnt_r + OF_CW'(wr_en) - OF_CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wr_ptr_r] <= wr_data;
  end

  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];
  assign count    = cnt_r;

endmodule

/* hdl/cross_kernel_sharpen_3x3_top.sv */
// 3x3 cross sharpening filter for a raster-order component stream
//
// input channel: one 8-bit component per transfer, channels of a pixel
//   interleaved; tuser[0] set marks a drain transfer that flushes one
//   pending result at frame end (tdata ignored then)
// result channel: sharpened component in tdata, tuser[0] flags a border
//   component (value zero), tlast marks the last result of the frame
// config port: APB, frame_width at 0x0, frame_height at 0x4,
//   channel_count at 0x8; write only while no results are outstanding
// latency: a result leaves one row plus one pixel of components after its
//   own input; out_tvalid then follows the request, read and queue registers
// throughput: one transfer per clock while in_tready is high, set by the
//   single history write port and two dual-read copies for four taps a result
// reset: positions, pending count and newest-item window clear, registers
//   return to 640 x 480 with one channel; the history memory is not cleared
// stall: a 4-entry result queue takes results while out_tready is low;
//   in_tready drops once queue plus in-flight results fill it
module cross_kernel_sharpen_3x3_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cks_pkg::PIX_W-1:0] in_tdata,   // [7:0] component
  input  logic [0:0]                in_tuser,   // [0] mode
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cks_pkg::PIX_W-1:0] out_tdata,  // [7:0] filtered_value
  output logic [0:0]                out_tuser,  // [0] on_border
  output logic                      out_tlast,  // frame_end
  // configuration
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [3:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import cks_pkg::*;

  // register indexes, paddr[3:2]
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [CC_W-1:0]  cc_r;
  logic             cfg_wr;

  logic             in_xfer;
  logic             out_xfer;
  logic             wr_en;
  logic [HA_W-1:0]  wr_addr;
  logic [PIX_W-1:0] wr_data;
  cks_req_t         req_r;
  cks_taps_t        taps;
  cks_pipe_t        s2_r;
  cks_res_t         res;
  cks_res_t         head;
  logic [OF_CW-1:0] of_cnt;
  logic [OF_CW-1:0] occ;

  // ---------------- configuration registers ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_W'(640);
      fh_r <= FH_W'(480);
      cc_r <= CC_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_FRAME_WIDTH:   fw_r <= cfg_pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT:  fh_r <= cfg_pwdata[FH_W-1:0];
        REG_CHANNEL_COUNT: cc_r <= cfg_pwdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FRAME_WIDTH:   cfg_prdata = 32'(fw_r);
      REG_FRAME_HEIGHT:  cfg_prdata = 32'(fh_r);
      REG_CHANNEL_COUNT: cfg_prdata = 32'(cc_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // every in-flight lookup may still become a queue entry, so admit a new
  // transfer only while the queue has room for all of them plus one
  assign occ       = of_cnt + OF_CW'(req_r.valid) + OF_CW'(s2_r.valid);
  assign in_tready = occ < OF_CW'(OF_DEPTH);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  // ---------------- stage 1: position tracking, lookup request ----------------
  cks_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_width   (fw_r),
    .frame_height  (fh_r),
    .channel_count (cc_r),
    .accept        (in_xfer),
    .mode          (in_tuser[0]),
    .component     (in_tdata),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .req_r         (req_r)
  );

  // ---------------- stage 2: history read ----------------
  cks_hist u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .req     (req_r),
    .taps    (taps)
  );

  // control riding alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= req_r.valid;
    end
    s2_r.border <= req_r.border;
    s2_r.last   <= req_r.last;
    s2_r.down   <= req_r.down_val;
  end

  // ---------------- kernel and saturation ----------------
  cks_calc u_calc (
    .taps (taps),
    .pipe (s2_r),
    .res  (res)
  );

  // ---------------- result queue ----------------
  cks_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (s2_r.valid),
    .wr_data  (res),
    .rd_en    (out_xfer),
    .rd_valid (out_tvalid),
    .rd_data  (head),
    .count    (of_cnt)
  );

  assign out_tdata    = head.value;
  assign out_tuser[0] = head.border;
  assign out_tlast    = head.last;

`ifndef ASSERT_OFF
  // queue plus in-flight results never exceed the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OF_CW'(OF_DEPTH))
    else $error("result queue over-committed");

  // the last result of a frame lies on the bottom row
  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("frame end on a non-border component");

  // border components carry zero
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("border component with nonzero value");
`endif

endmodule
